// ----- rtl/dplt_pkg.sv -----
// Shared types, constants and helpers for the demand paging LRU translator.
package dplt_pkg;

	localparam int ADDR_W          = 20;
	localparam int PA_W            = 16;
	localparam int CNT32_W         = 32;
	localparam int EVP_W           = 7;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;
	localparam int PAGES_CFG_W     = 8;
	localparam int FRAMES_CFG_W    = 5;
	localparam int DEF_MAX_PAGES   = 128;
	localparam int DEF_MAX_FRAMES  = 16;
	localparam int DEF_OFFSET_BITS = 12;
	localparam logic [PAGES_CFG_W-1:0]  PAGES_RST  = 8'd100;
	localparam logic [FRAMES_CFG_W-1:0] FRAMES_RST = 5'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGES  = 2'd0,
		CFG_FRAMES = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [PAGES_CFG_W-1:0]  pages_in_use;
		logic [FRAMES_CFG_W-1:0] frames_in_use;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] logical_address;
		logic              write_access;
	} req_t;

	typedef struct packed {
		logic               address_ok;
		logic [PA_W-1:0]    physical_address;
		logic               page_fault;
		logic               evicted;
		logic [EVP_W-1:0]   evicted_page;
		logic               wrote_back;
		logic [CNT32_W-1:0] fault_total;
		logic [CNT32_W-1:0] disk_io_total;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_EVWR,
		ST_LOAD
	} state_t;

	function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

// ----- rtl/dplt_core.sv -----
// Translation engine: page table and frame table memories with the fault sequencer.
module dplt_core #(
	parameter int MAX_PAGES   = dplt_pkg::DEF_MAX_PAGES,
	parameter int MAX_FRAMES  = dplt_pkg::DEF_MAX_FRAMES,
	parameter int OFFSET_BITS = dplt_pkg::DEF_OFFSET_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dplt_pkg::cfg_t cfg,
	input  logic           start,
	output logic           busy,
	input  dplt_pkg::req_t req,
	output logic           res_valid,
	output dplt_pkg::res_t res
);
	import dplt_pkg::*;

	localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
	localparam int PTE_W   = 2 + FRAME_W;
	localparam int FTE_W   = PAGE_W + CNT32_W;

	logic [PTE_W-1:0] page_mem  [MAX_PAGES];
	logic [FTE_W-1:0] frame_mem [MAX_FRAMES];

	state_t state_q, state_d;

	logic [PAGE_W-1:0]      pm_raddr, pm_waddr, clr_q;
	logic [PTE_W-1:0]       pm_wdata, pm_rdata_q;
	logic                   pm_we;
	logic [FRAME_W-1:0]     fm_raddr, fm_waddr;
	logic [FTE_W-1:0]       fm_wdata, fm_rdata_q;
	logic                   fm_we;
	logic [MAX_FRAMES-1:0]  occ_q;

	logic [PAGE_W-1:0]      page_q, vowner_q, vp_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   wr_q;
	logic [FRAME_W-1:0]     frame_q, victim_q, ridx_s1;
	logic [CNT_W-1:0]       f_q, nf;
	logic                   rv_s1, have_v_q, ev_q, wb_q, done_q;
	logic [CNT32_W-1:0]     oldest_q, stamp_q, fault_q, disk_q;
	res_t                   res_q;

	logic [ADDR_W-1:0]      page_full;
	logic                   legal, accept, pm_res, pm_dirty, scan_free, scan_end;
	logic [FRAME_W-1:0]     pm_frame;
	logic [PAGE_W-1:0]      fm_owner;
	logic [CNT32_W-1:0]     fm_stamp, plim, nf32, stamp_hit, stamp_load;

	assign page_full = req.logical_address >> OFFSET_BITS;
	always_comb begin
		plim = (32'(cfg.pages_in_use) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
			: 32'(cfg.pages_in_use);
		if (cfg.frames_in_use == '0)
			nf32 = 32'd1;
		else if (32'(cfg.frames_in_use) > 32'(MAX_FRAMES))
			nf32 = 32'(MAX_FRAMES);
		else
			nf32 = 32'(cfg.frames_in_use);
	end
	assign nf    = nf32[CNT_W-1:0];
	assign legal = 32'(page_full) < plim;
	assign busy  = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign {pm_res, pm_dirty, pm_frame} = pm_rdata_q;
	assign {fm_owner, fm_stamp}         = fm_rdata_q;
	assign stamp_hit  = sat_inc(stamp_q);
	assign stamp_load = sat_inc(sat_inc(stamp_q));
	assign scan_free  = (f_q < nf) && !occ_q[f_q[FRAME_W-1:0]];
	assign scan_end   = (f_q == nf) && !rv_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == PAGE_W'(MAX_PAGES - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept && legal) state_d = ST_LOOK;
			ST_LOOK:  state_d = pm_res ? ST_IDLE : ST_SCAN;
			ST_SCAN: begin
				if (scan_free) state_d = ST_LOAD;
				else if (scan_end) state_d = ST_EVWR;
			end
			ST_EVWR:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pm_raddr = page_full[PAGE_W-1:0];
		pm_we    = 1'b0;
		pm_waddr = page_q;
		pm_wdata = '0;
		fm_raddr = f_q[FRAME_W-1:0];
		fm_we    = 1'b0;
		fm_waddr = frame_q;
		fm_wdata = {page_q, stamp_load};
		unique case (state_q)
			ST_CLEAR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
			end
			ST_LOOK: begin
				if (pm_res) begin
					pm_we    = 1'b1;
					pm_wdata = {1'b1, pm_dirty | wr_q, pm_frame};
					fm_we    = 1'b1;
					fm_waddr = pm_frame;
					fm_wdata = {page_q, stamp_hit};
				end
			end
			ST_SCAN:  pm_raddr = vowner_q;
			ST_EVWR: begin
				pm_we    = 1'b1;
				pm_waddr = vp_q;
				pm_wdata = '0;
			end
			ST_LOAD: begin
				pm_we    = 1'b1;
				pm_wdata = {1'b1, wr_q, frame_q};
				fm_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pm_rdata_q <= page_mem[pm_raddr];
		if (pm_we) page_mem[pm_waddr] <= pm_wdata;
		fm_rdata_q <= frame_mem[fm_raddr];
		if (fm_we) frame_mem[fm_waddr] <= fm_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			occ_q    <= '0;
			stamp_q  <= '0;
			fault_q  <= '0;
			disk_q   <= '0;
			done_q   <= 1'b0;
			rv_s1    <= 1'b0;
			have_v_q <= 1'b0;
			f_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_IDLE && accept && !legal)
				|| (state_q == ST_LOOK && pm_res) || (state_q == ST_LOAD);
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: ;
				ST_LOOK: begin
					if (pm_res) begin
						stamp_q <= stamp_hit;
					end else begin
						fault_q  <= sat_inc(fault_q);
						disk_q   <= sat_inc(disk_q);
						f_q      <= '0;
						rv_s1    <= 1'b0;
						have_v_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!scan_free && f_q < nf) begin
						f_q   <= f_q + 1'b1;
						rv_s1 <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1 && (!have_v_q || fm_stamp < oldest_q)) have_v_q <= 1'b1;
				end
				ST_EVWR: begin
					if (pm_dirty) disk_q <= sat_inc(disk_q);
				end
				ST_LOAD: begin
					occ_q[frame_q] <= 1'b1;
					stamp_q        <= stamp_load;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= f_q[FRAME_W-1:0];
		if (accept) begin
			page_q <= page_full[PAGE_W-1:0];
			off_q  <= req.logical_address[OFFSET_BITS-1:0];
			wr_q   <= req.write_access;
		end
		if (state_q == ST_LOOK) begin
			ev_q <= 1'b0;
			wb_q <= 1'b0;
			vp_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (scan_free) frame_q <= f_q[FRAME_W-1:0];
			if (rv_s1 && (!have_v_q || fm_stamp < oldest_q)) begin
				oldest_q <= fm_stamp;
				victim_q <= ridx_s1;
				vowner_q <= fm_owner;
			end
			if (scan_end) begin
				frame_q <= victim_q;
				vp_q    <= vowner_q;
				ev_q    <= 1'b1;
			end
		end
		if (state_q == ST_EVWR) wb_q <= pm_dirty;
		if (state_q == ST_IDLE && accept && !legal) begin
			res_q.address_ok       <= 1'b0;
			res_q.physical_address <= '0;
			res_q.page_fault       <= 1'b0;
			res_q.evicted          <= 1'b0;
			res_q.evicted_page     <= '0;
			res_q.wrote_back       <= 1'b0;
			res_q.fault_total      <= fault_q;
			res_q.disk_io_total    <= disk_q;
		end
		if (state_q == ST_LOOK && pm_res) begin
			res_q.address_ok       <= 1'b1;
			res_q.physical_address <= PA_W'((32'(pm_frame) << OFFSET_BITS) | 32'(off_q));
			res_q.page_fault       <= 1'b0;
			res_q.evicted          <= 1'b0;
			res_q.evicted_page     <= '0;
			res_q.wrote_back       <= 1'b0;
			res_q.fault_total      <= fault_q;
			res_q.disk_io_total    <= disk_q;
		end
		if (state_q == ST_LOAD) begin
			res_q.address_ok       <= 1'b1;
			res_q.physical_address <= PA_W'((32'(frame_q) << OFFSET_BITS) | 32'(off_q));
			res_q.page_fault       <= 1'b1;
			res_q.evicted          <= ev_q;
			res_q.evicted_page     <= EVP_W'(32'(vp_q));
			res_q.wrote_back       <= wb_q;
			res_q.fault_total      <= fault_q;
			res_q.disk_io_total    <= disk_q;
		end
	end

	assign res_valid = done_q;
	assign res       = res_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && legal) |=> busy) else $error("Accepted transfer did not raise busy.");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy) else $error("Result strobe outside the idle state.");
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.page_fault) |-> (!res.evicted && !res.wrote_back))
		else $error("Eviction reported without a fault.");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.address_ok) |-> (res.physical_address == '0 && !res.page_fault))
		else $error("Error result carries translation data.");

endmodule

// ----- rtl/demand_paging_lru_translator.sv -----
// Top level of the demand paging translator: configuration registers and the engine.
//
// Channel  Direction  Handshake               Payload
// access   in         start, busy             req (logical_address, write_access)
// result   out        res_valid strobe        res (translation, eviction, totals)
// config   in         cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A hit strobes its result after the LOOK state; an illegal page in the next cycle.
// A fault scans the frame table one frame a cycle: the first free frame goes to LOAD;
// an eviction scans all nf frames, then EVWR and LOAD, with nf the effective frame count.
// After reset a clearing pass runs over every page table entry with busy high.
// Results are strobed for one cycle and cannot be stalled; configuration is always ready.
module demand_paging_lru_translator #(
	parameter int MAX_PAGES   = dplt_pkg::DEF_MAX_PAGES,
	parameter int MAX_FRAMES  = dplt_pkg::DEF_MAX_FRAMES,
	parameter int OFFSET_BITS = dplt_pkg::DEF_OFFSET_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  dplt_pkg::req_t                      req,
	output logic                                res_valid,
	output dplt_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dplt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dplt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dplt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pages_in_use  <= PAGES_RST;
			cfg_q.frames_in_use <= FRAMES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAGES:  cfg_q.pages_in_use  <= cfg_data[PAGES_CFG_W-1:0];
				CFG_FRAMES: cfg_q.frames_in_use <= cfg_data[FRAMES_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	dplt_core #(
		.MAX_PAGES  (MAX_PAGES),
		.MAX_FRAMES (MAX_FRAMES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench for the demand paging LRU translator with a local LRU model.
module tb;
	import dplt_pkg::*;

	localparam int NPAGES = DEF_MAX_PAGES;
	localparam int NFRAMES = DEF_MAX_FRAMES;
	localparam int OFFB = DEF_OFFSET_BITS;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic res_valid;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	demand_paging_lru_translator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the translator state.
	logic [7:0] m_pages;
	logic [4:0] m_frames;
	bit m_resident[NPAGES];
	logic [3:0] m_frame_of[NPAGES];
	bit m_dirty[NPAGES];
	logic [31:0] m_stamp[NPAGES];
	bit m_occupied[NFRAMES];
	logic [6:0] m_owner[NFRAMES];
	logic [31:0] m_stamp_ctr, m_fault_ctr, m_io_ctr;

	res_t expected_results[$];
	int fail_count = 0;
	bit quiet = 1'b0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [31:0] sat_up(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic res_t translate(input logic [ADDR_W-1:0] a, input logic wr);
		res_t r;
		int pg, npg, nf, fr, vp;
		logic [31:0] oldest;
		r = '0;
		pg = a >> OFFB;
		npg = (m_pages > NPAGES) ? NPAGES : m_pages;
		nf = (m_frames == 0) ? 1 : ((m_frames > NFRAMES) ? NFRAMES : m_frames);
		if (pg < npg) begin
			r.address_ok = 1'b1;
			if (!m_resident[pg]) begin
				r.page_fault = 1'b1;
				m_fault_ctr = sat_up(m_fault_ctr);
				fr = nf;
				for (int f = 0; f < nf; f++)
					if (!m_occupied[f] && fr == nf) fr = f;
				if (fr == nf) begin
					fr = 0;
					oldest = m_stamp[m_owner[0]];
					for (int f = 1; f < nf; f++)
						if (m_stamp[m_owner[f]] < oldest) begin
							oldest = m_stamp[m_owner[f]];
							fr = f;
						end
					vp = m_owner[fr];
					r.evicted = 1'b1;
					r.evicted_page = vp[6:0];
					if (m_dirty[vp]) begin
						r.wrote_back = 1'b1;
						m_io_ctr = sat_up(m_io_ctr);
					end
					m_resident[vp] = 1'b0;
					m_dirty[vp] = 1'b0;
				end
				m_io_ctr = sat_up(m_io_ctr);
				m_occupied[fr] = 1'b1;
				m_owner[fr] = pg[6:0];
				m_resident[pg] = 1'b1;
				m_frame_of[pg] = fr[3:0];
				m_dirty[pg] = 1'b0;
				m_stamp_ctr = sat_up(m_stamp_ctr);
				m_stamp[pg] = m_stamp_ctr;
			end
			m_stamp_ctr = sat_up(m_stamp_ctr);
			m_stamp[pg] = m_stamp_ctr;
			if (wr) m_dirty[pg] = 1'b1;
			r.physical_address = {m_frame_of[pg], a[OFFB-1:0]};
		end
		r.fault_total = m_fault_ctr;
		r.disk_io_total = m_io_ctr;
		return r;
	endfunction

	task automatic send_access(input logic [ADDR_W-1:0] a, input logic wr);
		@(negedge clk);
		start <= 1'b1;
		req <= '{logical_address: a, write_access: wr};
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		expected_results.push_back(translate(a, wr));
	endtask

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 11));
	endtask

	task automatic drain();
		idle_sender(1);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx == CFG_PAGES) m_pages = val;
		else m_frames = val[4:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] addr_of(input int pg, input logic [OFFB-1:0] off);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(pg);
		return (a << OFFB) | ADDR_W'(off);
	endfunction

	always @(posedge clk) begin
		res_t w;
		if (arst_n && res_valid) begin
			if (expected_results.size() == 0) begin
				report("unexpected result", 32'd1, 32'd0);
			end else begin
				w = expected_results.pop_front();
				if (res.address_ok !== w.address_ok)
					report("address_ok", 32'(res.address_ok), 32'(w.address_ok));
				if (res.physical_address !== w.physical_address)
					report("physical_address", 32'(res.physical_address),
						32'(w.physical_address));
				if (res.page_fault !== w.page_fault)
					report("page_fault", 32'(res.page_fault), 32'(w.page_fault));
				if (res.evicted !== w.evicted)
					report("evicted", 32'(res.evicted), 32'(w.evicted));
				if (res.evicted_page !== w.evicted_page)
					report("evicted_page", 32'(res.evicted_page), 32'(w.evicted_page));
				if (res.wrote_back !== w.wrote_back)
					report("wrote_back", 32'(res.wrote_back), 32'(w.wrote_back));
				if (res.fault_total !== w.fault_total)
					report("fault_total", res.fault_total, w.fault_total);
				if (res.disk_io_total !== w.disk_io_total)
					report("disk_io_total", res.disk_io_total, w.disk_io_total);
			end
		end
	end

	int stalled_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) stalled_cycles = 0;
		else stalled_cycles++;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_access(addr_of(0, 12'h000), 1'b0);
		send_access(addr_of(0, 12'hFFF), 1'b1);
		send_access(addr_of(99, 12'hABC), 1'b0);
		send_access(addr_of(100, 12'h123), 1'b1);
		send_access(20'hFFFFF, 1'b1);
		send_access(addr_of(127, 12'h555), 1'b0);
	endtask

	task automatic test_fill_and_evict();
		for (int p = 1; p <= 12; p++) begin
			send_access(addr_of(p, 12'hAAA ^ p[11:0]), p[0]);
			maybe_idle();
		end
		send_access(addr_of(0, 12'h001), 1'b0);
		send_access(addr_of(40, 12'h800), 1'b1);
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_PAGES, 8'd0);
		send_access(addr_of(0, 12'h000), 1'b1);
		write_reg(CFG_PAGES, 8'd255);
		send_access(20'hFFFFF, 1'b1);
		send_access(addr_of(127, 12'hFFF), 1'b1);
		write_reg(CFG_FRAMES, 8'hE0);
		send_access(addr_of(50, 12'h010), 1'b0);
		send_access(addr_of(51, 12'h020), 1'b1);
		// Frames above the new count stay mapped and still hit.
		send_access(addr_of(127, 12'h0F0), 1'b0);
		write_reg(CFG_FRAMES, 8'd31);
		for (int p = 60; p < 80; p++) send_access(addr_of(p, p[11:0]), 1'b1);
		write_reg(CFG_FRAMES, 8'd1);
		send_access(addr_of(90, 12'h000), 1'b0);
		write_reg(CFG_PAGES, 8'd1);
		send_access(addr_of(1, 12'h000), 1'b0);
		send_access(addr_of(0, 12'h777), 1'b1);
		write_reg(CFG_PAGES, 8'd128);
		write_reg(CFG_FRAMES, 8'd16);
	endtask

	task automatic test_random(input int n);
		int ws_base, ws_size, npg, pg, r;
		logic [ADDR_W-1:0] a;
		ws_base = 0;
		ws_size = 8;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 149) begin
				write_reg(CFG_PAGES, $urandom_range(0, 9) == 0 ? 8'($urandom)
					: 8'($urandom_range(1, 128)));
				write_reg(CFG_FRAMES, 8'($urandom));
				ws_size = $urandom_range(2, 24);
			end
			if (i == n - 120) quiet = 1'b1;
			npg = (m_pages > NPAGES) ? NPAGES : m_pages;
			if (npg == 0) npg = 1;
			if (i % 40 == 0) ws_base = $urandom_range(0, npg - 1);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				pg = (ws_base + $urandom_range(0, ws_size - 1)) % npg;
				a = addr_of(pg, 12'($urandom));
			end else if (r < 88) begin
				a = 20'($urandom);
			end else begin
				pg = npg - 1 + $urandom_range(0, 2);
				a = addr_of(pg, 12'($urandom));
			end
			send_access(a, 1'($urandom));
			maybe_idle();
		end
	endtask

	initial begin
		m_pages = PAGES_RST;
		m_frames = FRAMES_RST;
		for (int p = 0; p < NPAGES; p++) begin
			m_resident[p] = 1'b0;
			m_dirty[p] = 1'b0;
			m_stamp[p] = '0;
			m_frame_of[p] = '0;
		end
		for (int f = 0; f < NFRAMES; f++) begin
			m_occupied[f] = 1'b0;
			m_owner[f] = '0;
		end
		m_stamp_ctr = '0;
		m_fault_ctr = '0;
		m_io_ctr = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_fill_and_evict();
		drain();
		test_register_extremes();
		test_random(820);
		drain();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
